>>> rtl/fhcb_pkg.sv
package fhcb_pkg;

    localparam int HDR_BYTES = 13;
    localparam int HDR_W     = HDR_BYTES * 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // configuration register indexes
    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN = 2'd2;

    // header start vs payload byte
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_NO_FRAME = 2'd2
    } err_code_t;

    typedef struct packed {
        logic update;   // fold one byte into the running CRC
        logic fresh;    // start from the initial value instead of the register
    } crc_ctl_t;

    // CRC-16/CCITT-FALSE over one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/fhcb_crc16.sv
module fhcb_crc16 (
    input  logic              clk,
    input  logic              rst_n,
    input  fhcb_pkg::crc_ctl_t ctl,
    input  logic [7:0]        data_byte,
    output logic [15:0]       crc
);
    import fhcb_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] base;

    always_comb
    begin
        base     = ctl.fresh ? CRC_INIT : crc_reg;
        crc_next = ctl.update ? crc16_byte(base, data_byte) : crc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

>>> rtl/frame_header_crc16_builder.sv
// Accepted items go to the job registers; results go through the output register
// to out_*, one per cycle while out_ready holds: 1 per payload byte (3 on the last,
// which adds the CRC), 13 per start (15 if empty, 1 on error). The single output
// register and the one-byte CRC step set that rate; a new item is taken in the
// cycle the previous one hands over its last result. Reset (rst_n low, asynchronous):
// no frame open, CRC 0xFFFF, control registers at defaults, payload ones not reset.
module frame_header_crc16_builder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  msg_type,
    input  logic [7:0]  flag_bits,
    input  logic [15:0] sequence_number,
    input  logic [31:0] session_number,
    input  logic [15:0] payload_length,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        run_end,
    output logic [1:0]  error_code
);
    import fhcb_pkg::*;

    // configuration registers
    logic [15:0] magic_reg;
    logic [7:0]  version_reg;
    logic [15:0] max_len_reg;

    // frame tracking, updated in item order at accept time
    logic        frame_open_reg, frame_open_next;
    logic [15:0] remaining_reg, remaining_next;

    // current item being expanded into results
    logic             job_valid_reg, job_valid_next;
    logic [HDR_W-1:0] bytes_reg, bytes_next;      // bytes still to send, low byte first
    logic [3:0]       data_left_reg, data_left_next;
    logic [1:0]       crc_left_reg, crc_left_next;
    logic             fresh_reg, fresh_next;      // next data byte opens a new CRC
    err_code_t        err_reg, err_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       frame_end_reg, frame_end_next;
    logic       run_end_reg, run_end_next;
    err_code_t  error_code_reg, error_code_next;

    logic        in_acc;
    logic        out_load;
    logic        emit;
    logic        last;
    logic        job_done;
    crc_ctl_t    crc_ctl;
    logic [15:0] crc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= 16'd0;
            version_reg <= 8'd1;
            max_len_reg <= 16'd1024;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAGIC:   magic_reg   <= cfg_data;
                CFG_VERSION: version_reg <= cfg_data[7:0];
                CFG_MAX_LEN: max_len_reg <= cfg_data;
                default:     ;   // index beyond the list: drop the write
            endcase
        end
    end

    // The output register takes a new result when empty or being drained.
    assign out_load = !out_valid_reg || out_ready;
    assign emit     = job_valid_reg && out_load;

    always_comb
    begin
        if (err_reg != ERR_NONE)
            last = 1'b1;
        else if (data_left_reg != 4'd0)
            last = (data_left_reg == 4'd1) && (crc_left_reg == 2'd0);
        else
            last = (crc_left_reg == 2'd1);
    end

    assign job_done = emit && last;
    assign in_ready = !job_valid_reg || job_done;
    assign in_acc   = in_valid && in_ready;

    // Fold each data byte into the CRC as it moves to the output register.
    always_comb
    begin
        crc_ctl.update = emit && (err_reg == ERR_NONE) && (data_left_reg != 4'd0);
        crc_ctl.fresh  = fresh_reg;
    end

    fhcb_crc16 u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (crc_ctl),
        .data_byte (bytes_reg[7:0]),
        .crc       (crc)
    );

    // Job and frame state
    always_comb
    begin
        frame_open_next = frame_open_reg;
        remaining_next  = remaining_reg;
        job_valid_next  = job_valid_reg;
        bytes_next      = bytes_reg;
        data_left_next  = data_left_reg;
        crc_left_next   = crc_left_reg;
        fresh_next      = fresh_reg;
        err_next        = err_reg;

        // advance the current job by one result
        if (emit)
        begin
            if (data_left_reg != 4'd0)
            begin
                bytes_next     = {8'h00, bytes_reg[HDR_W-1:8]};
                data_left_next = data_left_reg - 4'd1;
                fresh_next     = 1'b0;
            end
            else if (crc_left_reg != 2'd0)
            begin
                crc_left_next = crc_left_reg - 2'd1;
            end
            if (last)
                job_valid_next = 1'b0;
        end

        // load a new job; the old one has finished if this happens
        if (in_acc)
        begin
            job_valid_next = 1'b1;
            fresh_next     = 1'b0;
            crc_left_next  = 2'd0;
            err_next       = ERR_NONE;
            bytes_next     = {{(HDR_W-8){1'b0}}, data_byte};
            data_left_next = 4'd1;
            if (action == ACT_START)
            begin
                // any open frame is abandoned here
                frame_open_next = 1'b0;
                remaining_next  = 16'd0;
                if (payload_length > max_len_reg)
                begin
                    err_next       = ERR_TOO_LONG;
                    data_left_next = 4'd0;
                end
                else
                begin
                    bytes_next     = {payload_length, session_number, sequence_number,
                                      flag_bits, msg_type, version_reg, magic_reg};
                    data_left_next = 4'(HDR_BYTES);
                    fresh_next     = 1'b1;
                    if (payload_length == 16'd0)
                        crc_left_next = 2'd2;
                    else
                    begin
                        frame_open_next = 1'b1;
                        remaining_next  = payload_length;
                    end
                end
            end
            else if (!frame_open_reg)
            begin
                // payload byte with no frame: flag it, leave state alone
                err_next       = ERR_NO_FRAME;
                data_left_next = 4'd0;
            end
            else
            begin
                remaining_next = remaining_reg - 16'd1;
                if (remaining_reg == 16'd1)
                begin
                    crc_left_next   = 2'd2;
                    frame_open_next = 1'b0;
                end
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        frame_end_next  = frame_end_reg;
        run_end_next    = run_end_reg;
        error_code_next = error_code_reg;

        if (out_load)
            out_valid_next = emit;

        if (emit)
        begin
            run_end_next    = last;
            error_code_next = err_reg;
            frame_end_next  = 1'b0;
            if (err_reg != ERR_NONE)
                out_byte_next = 8'h00;
            else if (data_left_reg != 4'd0)
                out_byte_next = bytes_reg[7:0];
            else if (crc_left_reg == 2'd2)
                out_byte_next = crc[7:0];
            else
            begin
                out_byte_next  = crc[15:8];
                frame_end_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            remaining_reg  <= 16'd0;
            job_valid_reg  <= 1'b0;
            data_left_reg  <= 4'd0;
            crc_left_reg   <= 2'd0;
            fresh_reg      <= 1'b0;
            err_reg        <= ERR_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            remaining_reg  <= remaining_next;
            job_valid_reg  <= job_valid_next;
            data_left_reg  <= data_left_next;
            crc_left_reg   <= crc_left_next;
            fresh_reg      <= fresh_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        bytes_reg      <= bytes_next;
        out_byte_reg   <= out_byte_next;
        frame_end_reg  <= frame_end_next;
        run_end_reg    <= run_end_next;
        error_code_reg <= error_code_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign frame_end  = frame_end_reg;
    assign run_end    = run_end_reg;
    assign error_code = error_code_reg;

endmodule
